// ----- rtl/cfa_pkg.sv -----
// Shared types, constants and helpers for the Curve25519 field arithmetic unit.
package cfa_pkg;

    localparam int LIMB_W = 32;
    localparam int NLIMB  = 8;
    localparam int FE_W   = LIMB_W * NLIMB;

    // Folding constants: 2^256 = 38 and 2^255 = 19 modulo p.
    localparam logic [LIMB_W-1:0] FOLD_K = 32'd38;
    localparam logic [4:0]        TOP_K  = 5'd19;

    // Inversion runs 506 multiplications; steps up to INV_LOOP_END follow the
    // square / multiply-by-x alternation, the rest form the fixed tail.
    localparam logic [8:0] INV_LOOP_END  = 9'd497;
    localparam logic [8:0] INV_LAST_STEP = 9'd505;

    // Operation codes of an input item.
    typedef logic [2:0] t_op;
    localparam t_op OP_ADD  = 3'd0;
    localparam t_op OP_SUB  = 3'd1;
    localparam t_op OP_MUL  = 3'd2;
    localparam t_op OP_MULC = 3'd3;
    localparam t_op OP_NORM = 3'd4;
    localparam t_op OP_INV  = 3'd5;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_ADD,
        DP_SUB,
        DP_FOLD_ADD,
        DP_FOLD_SUB,
        DP_MAC,
        DP_RED,
        DP_MULC,
        DP_NORM1,
        DP_NORM2,
        DP_CLEAR,
        DP_NEXT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] i;
        logic [3:0] j;
        logic       sq;
    } t_dp_cmd;

    // True when inversion step n squares the previous result.
    function automatic logic inv_is_square(input logic [8:0] n);
        logic res;
        if (n <= INV_LOOP_END) begin
            res = ~n[0];
        end else begin
            res = (n == 9'd498) || (n == 9'd499) || (n == 9'd501) ||
                  (n == 9'd502) || (n == 9'd504);
        end
        return res;
    endfunction

    // Carry times 38, built from shifts.
    function automatic logic [37:0] fold_k_mul(input logic [LIMB_W-1:0] c);
        logic [37:0] w;
        w = {6'b0, c};
        return (w << 5) + (w << 2) + (w << 1);
    endfunction

endpackage

// ----- rtl/cfa_if.sv -----
// Request and response channel interfaces of the field arithmetic unit.
interface cfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] a_w0;
    logic [63:0] a_w1;
    logic [63:0] a_w2;
    logic [63:0] a_w3;
    logic [63:0] b_w0;
    logic [63:0] b_w1;
    logic [63:0] b_w2;
    logic [63:0] b_w3;

    modport source (output valid, op, a_w0, a_w1, a_w2, a_w3,
                    b_w0, b_w1, b_w2, b_w3, input ready);
    modport sink   (input valid, op, a_w0, a_w1, a_w2, a_w3,
                    b_w0, b_w1, b_w2, b_w3, output ready);
endinterface

interface cfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] r_w0;
    logic [63:0] r_w1;
    logic [63:0] r_w2;
    logic [63:0] r_w3;

    modport source (output valid, r_w0, r_w1, r_w2, r_w3, input ready);
    modport sink   (input valid, r_w0, r_w1, r_w2, r_w3, output ready);
endinterface

// ----- rtl/cfa_dp.sv -----
// Datapath: operand registers, product buffer, shared 32x32 MAC and 256-bit add paths.
module cfa_dp
    import cfa_pkg::*;
(
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    input  t_op               i_op,
    input  logic [FE_W-1:0]   i_a,
    input  logic [FE_W-1:0]   i_b,
    output logic [FE_W-1:0]   o_res
);

    logic [NLIMB-1:0][LIMB_W-1:0]   r_a;
    logic [NLIMB-1:0][LIMB_W-1:0]   r_b;
    logic [NLIMB-1:0][LIMB_W-1:0]   r_x;
    logic [2*NLIMB-1:0][LIMB_W-1:0] r_t;
    logic [FE_W-1:0]                r_acc;
    logic [LIMB_W-1:0]              r_c;

    logic [LIMB_W-1:0]   mx;
    logic [LIMB_W-1:0]   my;
    logic [LIMB_W-1:0]   ad;
    logic [3:0]          tidx;
    logic [2*LIMB_W-1:0] prod;
    logic [FE_W:0]       sum_ab;
    logic [FE_W:0]       dif_ab;
    logic [FE_W:0]       sum_fold;
    logic [FE_W:0]       dif_fold;
    logic [FE_W-1:0]     norm_w;
    logic [FE_W-1:0]     norm_t;

    // Operand selection for the shared multiply-accumulate unit.
    assign tidx = {1'b0, i_cmd.i} + i_cmd.j;

    always_comb begin
        mx = '0;
        my = '0;
        ad = '0;
        case (i_cmd.op)
            DP_MAC: begin
                mx = r_a[i_cmd.i];
                my = i_cmd.j[3] ? '0 : r_b[i_cmd.j[2:0]];
                ad = r_t[tidx];
            end
            DP_RED: begin
                mx = r_t[NLIMB];
                my = FOLD_K;
                ad = r_t[0];
            end
            DP_MULC: begin
                mx = r_a[i_cmd.i];
                my = r_b[0];
            end
            default: begin
                mx = '0;
            end
        endcase
    end

    assign prod = ({32'b0, mx} * {32'b0, my}) + {32'b0, ad} + {32'b0, r_c};

    // Wide add and subtract paths.
    assign sum_ab   = {1'b0, r_a} + {1'b0, r_b};
    assign dif_ab   = {1'b0, r_a} - {1'b0, r_b};
    assign sum_fold = {1'b0, r_acc} + {{(FE_W-37){1'b0}}, fold_k_mul(r_c)};
    assign dif_fold = {1'b0, r_acc} - {{(FE_W-31){1'b0}}, (r_c[0] ? FOLD_K : 32'd0)};
    assign norm_w   = {1'b0, r_a[NLIMB-1][LIMB_W-2:0], r_a[NLIMB-2:0]}
                      + {{(FE_W-5){1'b0}}, (r_a[NLIMB-1][LIMB_W-1] ? TOP_K : 5'd0)};
    assign norm_t   = r_acc + {{(FE_W-5){1'b0}}, TOP_K};

    // Register updates under the controller's command.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_a <= i_a;
                r_b <= (i_op == OP_INV) ? i_a : i_b;
                r_x <= i_a;
                r_t <= '0;
                r_c <= '0;
            end
            DP_NEXT: begin
                r_a <= r_acc;
                r_b <= i_cmd.sq ? r_acc : r_x;
                r_t <= '0;
                r_c <= '0;
            end
            DP_ADD: begin
                r_acc <= sum_ab[FE_W-1:0];
                r_c   <= {31'b0, sum_ab[FE_W]};
            end
            DP_SUB: begin
                r_acc <= dif_ab[FE_W-1:0];
                r_c   <= {31'b0, dif_ab[FE_W]};
            end
            DP_FOLD_ADD: begin
                r_acc <= sum_fold[FE_W-1:0];
                r_c   <= {31'b0, sum_fold[FE_W]};
            end
            DP_FOLD_SUB: begin
                r_acc <= dif_fold[FE_W-1:0];
                r_c   <= {31'b0, dif_fold[FE_W]};
            end
            DP_MAC: begin
                r_t[tidx] <= prod[LIMB_W-1:0];
                r_c       <= prod[2*LIMB_W-1:LIMB_W];
            end
            DP_RED: begin
                r_t   <= {{LIMB_W{1'b0}}, r_t[2*NLIMB-1:1]};
                r_acc <= {prod[LIMB_W-1:0], r_acc[FE_W-1:LIMB_W]};
                r_c   <= prod[2*LIMB_W-1:LIMB_W];
            end
            DP_MULC: begin
                r_acc <= {prod[LIMB_W-1:0], r_acc[FE_W-1:LIMB_W]};
                r_c   <= prod[2*LIMB_W-1:LIMB_W];
            end
            DP_NORM1: begin
                r_acc <= norm_w;
            end
            DP_NORM2: begin
                if (norm_t[FE_W-1]) begin
                    r_acc <= {1'b0, norm_t[FE_W-2:0]};
                end
            end
            DP_CLEAR: begin
                r_acc <= '0;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_res = r_acc;

endmodule

// ----- rtl/cfa_ctrl.sv -----
// Controller: sequences each operation as datapath commands and runs the handshakes.
module cfa_ctrl
    import cfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_op     i_op,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_ADD   = 12'b0000_0000_0010,
        S_SUB   = 12'b0000_0000_0100,
        S_FOLDA = 12'b0000_0000_1000,
        S_FOLDS = 12'b0000_0001_0000,
        S_MAC   = 12'b0000_0010_0000,
        S_RED   = 12'b0000_0100_0000,
        S_MULC  = 12'b0000_1000_0000,
        S_NORM1 = 12'b0001_0000_0000,
        S_NORM2 = 12'b0010_0000_0000,
        S_NEXT  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_i, n_i;
    logic [3:0] r_j, n_j;
    logic [1:0] r_cnt, n_cnt;
    logic [8:0] r_step, n_step;
    logic       r_inv, n_inv;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign accept      = i_in_valid && o_in_ready;

    // Next-state and command logic.
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_cnt     = r_cnt;
        n_step    = r_step;
        n_inv     = r_inv;
        o_cmd.op  = DP_IDLE;
        o_cmd.i   = r_i;
        o_cmd.j   = r_j;
        o_cmd.sq  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = DP_LOAD;
                    n_i      = '0;
                    n_j      = '0;
                    n_cnt    = '0;
                    n_step   = '0;
                    n_inv    = (i_op == OP_INV);
                    unique case (i_op) inside
                        OP_ADD:          n_state = S_ADD;
                        OP_SUB:          n_state = S_SUB;
                        OP_MUL, OP_INV:  n_state = S_MAC;
                        OP_MULC:         n_state = S_MULC;
                        OP_NORM:         n_state = S_NORM1;
                        default:         n_state = S_DONE;
                    endcase
                    if (i_op != OP_ADD && i_op != OP_SUB && i_op != OP_MUL &&
                        i_op != OP_MULC && i_op != OP_NORM && i_op != OP_INV) begin
                        o_cmd.op = DP_CLEAR;
                    end
                end
            end
            S_ADD: begin
                o_cmd.op = DP_ADD;
                n_cnt    = '0;
                n_state  = S_FOLDA;
            end
            S_SUB: begin
                o_cmd.op = DP_SUB;
                n_cnt    = '0;
                n_state  = S_FOLDS;
            end
            S_FOLDA: begin
                o_cmd.op = DP_FOLD_ADD;
                n_cnt    = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = (r_inv && r_step != INV_LAST_STEP) ? S_NEXT : S_DONE;
                end
            end
            S_FOLDS: begin
                o_cmd.op = DP_FOLD_SUB;
                n_cnt    = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = S_DONE;
                end
            end
            S_MAC: begin
                o_cmd.op = DP_MAC;
                if (r_j == 4'd8) begin
                    n_j = '0;
                    n_i = r_i + 3'd1;
                    if (r_i == 3'd7) begin
                        n_state = S_RED;
                    end
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_RED: begin
                o_cmd.op = DP_RED;
                n_i      = r_i + 3'd1;
                n_cnt    = '0;
                if (r_i == 3'd7) begin
                    n_state = S_FOLDA;
                end
            end
            S_MULC: begin
                o_cmd.op = DP_MULC;
                n_i      = r_i + 3'd1;
                n_cnt    = '0;
                if (r_i == 3'd7) begin
                    n_state = S_FOLDA;
                end
            end
            S_NORM1: begin
                o_cmd.op = DP_NORM1;
                n_state  = S_NORM2;
            end
            S_NORM2: begin
                o_cmd.op = DP_NORM2;
                n_state  = S_DONE;
            end
            S_NEXT: begin
                o_cmd.op = DP_NEXT;
                o_cmd.sq = inv_is_square(r_step + 9'd1);
                n_step   = r_step + 9'd1;
                n_i      = '0;
                n_j      = '0;
                n_state  = S_MAC;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_step  <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_inv   <= n_inv;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("controller stayed idle after taking an item");
    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= INV_LAST_STEP)
        else $error("inversion step counter overran");
    a_mac_col_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_j <= 4'd8))
        else $error("MAC column index out of range");
    a_next_only_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> r_inv)
        else $error("inversion step issued outside an inversion");
`endif

endmodule

// ----- rtl/curve25519_field_alu.sv -----
// Add, sub, normalise, mul-by-constant and multiply each run as a sequence of datapath
// commands from the accepting edge to the result; unused codes go straight to done.
// Invert takes 506 chained multiplies.
// The single 32x32 MAC unit sets the multiply time: 72 MAC steps, 8 reduction steps.
// One item at a time; the next item is taken once the result has been collected.
// Synchronous active-low reset returns the controller to idle; no clearing pass.
module curve25519_field_alu
    import cfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cfa_req_if.sink  i_req,
    cfa_rsp_if.source o_rsp
);

    t_dp_cmd         cmd;
    logic [FE_W-1:0] res;

    // Sequencing of each operation.
    cfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_op        (i_req.op),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // Arithmetic on the operands.
    cfa_dp u_dp (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .i_op  (i_req.op),
        .i_a   ({i_req.a_w3, i_req.a_w2, i_req.a_w1, i_req.a_w0}),
        .i_b   ({i_req.b_w3, i_req.b_w2, i_req.b_w1, i_req.b_w0}),
        .o_res (res)
    );

    assign o_rsp.r_w0 = res[63:0];
    assign o_rsp.r_w1 = res[127:64];
    assign o_rsp.r_w2 = res[191:128];
    assign o_rsp.r_w3 = res[255:192];

endmodule
